// ----- hdl/tccw_pkg.sv -----
// Shared types and constants for the text console character writer.
// No dependencies; imported by every module of the block.
`default_nettype none
package tccw_pkg;

    localparam int CELL_W       = 15;
    localparam int BUFFER_CELLS = 1 << CELL_W;
    localparam int COL_W        = 9;
    localparam int BYTE_W       = 8;
    localparam int WORD_W       = 16;
    localparam int DIV_CNT_W    = $clog2(CELL_W);
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    localparam logic [BYTE_W-1:0] CURSOR_ATTR = 8'h0F;
    localparam logic [BYTE_W-1:0] BLANK_CHAR  = 8'h20;
    localparam logic [CELL_W-1:0] TAB_STEP    = 15'd4;

    localparam logic [BYTE_W-1:0] CH_BS = 8'h08;
    localparam logic [BYTE_W-1:0] CH_HT = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_VT = 8'h0B;
    localparam logic [BYTE_W-1:0] CH_FF = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;

    localparam logic [1:0] REG_COLUMNS     = 2'd0;
    localparam logic [1:0] REG_SCROLL_ROWS = 2'd1;
    localparam logic [1:0] REG_TEXT_ATTR   = 2'd2;
    localparam logic [1:0] REG_CURSOR_FOLL = 2'd3;

    typedef struct packed {
        logic [COL_W-1:0]  columns;
        logic [BYTE_W-1:0] scroll_rows;
        logic [BYTE_W-1:0] text_attribute;
        logic              cursor_follow;
    } t_cfg;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_APPLY,
        CMD_DIV_WP,
        CMD_DIV_OFFS,
        CMD_DIV_STEP,
        CMD_NL_MUL,
        CMD_NL_SET,
        CMD_MARK_RD,
        CMD_MARK_PUT,
        CMD_SC_MUL,
        CMD_SC_SET,
        CMD_OFFS
    } t_dp_cmd;

    typedef enum logic [2:0] {
        CLS_PRINT,
        CLS_NL,
        CLS_TAB,
        CLS_VT,
        CLS_BS,
        CLS_FF
    } t_char_cls;

    typedef struct packed {
        t_char_cls cls;
        logic      div_last;
        logic      y_gt;
        logic      clear_done;
        logic      two_results;
    } t_dp_status;

endpackage
`default_nettype wire

// ----- hdl/tccw_regs.sv -----
// APB-style configuration registers of the character writer.
// Depends on tccw_pkg.
`default_nettype none
module tccw_regs
    import tccw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    t_cfg        r_cfg;
    logic [1:0]  reg_idx;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns        <= 9'd80;
            r_cfg.scroll_rows    <= '0;
            r_cfg.text_attribute <= '0;
            r_cfg.cursor_follow  <= 1'b1;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_COLUMNS:     r_cfg.columns        <= pwdata[COL_W-1:0];
                REG_SCROLL_ROWS: r_cfg.scroll_rows    <= pwdata[BYTE_W-1:0];
                REG_TEXT_ATTR:   r_cfg.text_attribute <= pwdata[BYTE_W-1:0];
                REG_CURSOR_FOLL: r_cfg.cursor_follow  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_COLUMNS:     prdata = {{(PDATA_W-COL_W){1'b0}}, r_cfg.columns};
            REG_SCROLL_ROWS: prdata = {{(PDATA_W-BYTE_W){1'b0}}, r_cfg.scroll_rows};
            REG_TEXT_ATTR:   prdata = {{(PDATA_W-BYTE_W){1'b0}}, r_cfg.text_attribute};
            REG_CURSOR_FOLL: prdata = {{(PDATA_W-1){1'b0}}, r_cfg.cursor_follow};
            default:         prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/tccw_dp.sv -----
// Datapath: cell store, position and window registers, serial divider,
// multiplier and result registers. Depends on tccw_pkg.
`default_nettype none
module tccw_dp
    import tccw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [BYTE_W-1:0] i_char_code,
    input  wire logic              i_out_sel,
    output t_dp_status             o_status,
    output logic                   o_cell_write_valid,
    output logic      [CELL_W-1:0] o_cell_address,
    output logic      [WORD_W-1:0] o_cell_word,
    output logic      [CELL_W-1:0] o_cursor_offset,
    output logic      [CELL_W-1:0] o_window_start,
    output logic                   o_last_result
);

    // only the character byte is ever read back, so only it is stored
    logic [BYTE_W-1:0] r_mem [BUFFER_CELLS];

    logic [CELL_W-1:0]    r_wp;
    logic [CELL_W-1:0]    r_ds;
    logic [CELL_W-1:0]    r_clr;
    logic [1:0]           r_n;
    logic [BYTE_W-1:0]    r_ch;
    logic [CELL_W-1:0]    r_dvd;
    logic [COL_W-1:0]     r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CELL_W-1:0]    r_prod;
    logic [BYTE_W-1:0]    r_rd;
    logic [CELL_W-1:0]    r_addr [2];
    logic [WORD_W-1:0]    r_word [2];
    logic [CELL_W-1:0]    r_offs;

    t_char_cls                cls;
    logic [COL_W-1:0]         cols;
    logic [CELL_W-1:0]        offs_now;
    logic [CELL_W-1:0]        bs_pos;
    logic [COL_W:0]           rem_sh;
    logic                     q_bit;
    logic [COL_W:0]           rem_diff;
    logic [CELL_W-1:0]        mul_a;
    logic [CELL_W+COL_W-1:0]  prod_full;
    logic [CELL_W:0]          vt_sum;
    logic                     put_en;
    logic [CELL_W-1:0]        put_addr;
    logic [WORD_W-1:0]        put_word;
    logic                     mem_we;

    always_comb begin
        unique case (r_ch) inside
            CH_LF, CH_CR: cls = CLS_NL;
            CH_HT:        cls = CLS_TAB;
            CH_VT:        cls = CLS_VT;
            CH_BS:        cls = CLS_BS;
            CH_FF:        cls = CLS_FF;
            default:      cls = CLS_PRINT;
        endcase
    end

    assign cols      = (i_cfg.columns == '0) ? COL_W'(1) : i_cfg.columns;
    assign offs_now  = r_wp - r_ds;
    assign bs_pos    = (r_wp != '0) ? r_wp - CELL_W'(1) : '0;
    assign rem_sh    = {r_rem, r_dvd[CELL_W-1]};
    assign q_bit     = rem_sh >= {1'b0, cols};
    assign rem_diff  = rem_sh - {1'b0, cols};
    assign mul_a     = (i_cmd == CMD_NL_MUL) ? r_dvd + CELL_W'(1)
                                             : r_dvd - {{(CELL_W-BYTE_W){1'b0}}, i_cfg.scroll_rows};
    assign prod_full = {{COL_W{1'b0}}, mul_a} * {{CELL_W{1'b0}}, cols};
    assign vt_sum    = {1'b0, r_wp} + {{(CELL_W+1-COL_W){1'b0}}, cols};

    always_comb begin
        put_en   = 1'b0;
        put_addr = r_wp;
        put_word = '0;
        case (i_cmd)
            CMD_APPLY: begin
                if (cls == CLS_PRINT) begin
                    put_en   = 1'b1;
                    put_word = {i_cfg.text_attribute, r_ch};
                end else if (cls == CLS_BS && i_cfg.cursor_follow) begin
                    put_en   = 1'b1;
                    put_addr = bs_pos;
                    put_word = {CURSOR_ATTR, BLANK_CHAR};
                end
            end
            CMD_MARK_PUT: begin
                put_en   = 1'b1;
                put_word = {CURSOR_ATTR, r_rd};
            end
            default: ;
        endcase
    end

    // the cursor mark keeps the character, so it never writes the store
    assign mem_we = (i_cmd == CMD_CLEAR) || (put_en && i_cmd == CMD_APPLY);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            if (i_cmd == CMD_CLEAR) begin
                r_mem[r_clr] <= '0;
            end else begin
                r_mem[put_addr] <= put_word[BYTE_W-1:0];
            end
        end
        if (i_cmd == CMD_MARK_RD) begin
            r_rd <= r_mem[r_wp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_ds  <= '0;
            r_clr <= '0;
            r_n   <= '0;
        end else begin
            if (put_en) begin
                r_n <= r_n + 2'd1;
            end
            case (i_cmd)
                CMD_CLEAR: r_clr <= r_clr + CELL_W'(1);
                CMD_LOAD:  r_n   <= '0;
                CMD_APPLY: begin
                    case (cls)
                        CLS_TAB:   r_wp <= r_wp + TAB_STEP;
                        CLS_VT:    r_wp <= vt_sum[CELL_W-1:0];
                        CLS_BS:    r_wp <= bs_pos;
                        CLS_PRINT: r_wp <= r_wp + CELL_W'(1);
                        CLS_FF: begin
                            r_wp <= '0;
                            r_ds <= '0;
                        end
                        default: ;
                    endcase
                end
                CMD_NL_SET: r_wp <= r_prod;
                CMD_SC_SET: r_ds <= r_ds + r_prod;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (put_en) begin
            r_addr[r_n[0]] <= put_addr;
            r_word[r_n[0]] <= put_word;
        end
        case (i_cmd)
            CMD_LOAD: begin
                r_ch      <= i_char_code;
                r_addr[0] <= '0;
                r_word[0] <= '0;
            end
            CMD_DIV_WP: begin
                r_dvd <= r_wp;
                r_rem <= '0;
                r_cnt <= '0;
            end
            CMD_DIV_OFFS: begin
                r_dvd <= offs_now;
                r_rem <= '0;
                r_cnt <= '0;
            end
            CMD_DIV_STEP: begin
                r_rem <= q_bit ? rem_diff[COL_W-1:0] : rem_sh[COL_W-1:0];
                r_dvd <= {r_dvd[CELL_W-2:0], q_bit};
                r_cnt <= r_cnt + DIV_CNT_W'(1);
            end
            CMD_NL_MUL, CMD_SC_MUL: r_prod <= prod_full[CELL_W-1:0];
            CMD_OFFS:               r_offs <= offs_now;
            default: ;
        endcase
    end

    assign o_status.cls         = cls;
    assign o_status.div_last    = (r_cnt == DIV_CNT_W'(CELL_W - 1));
    assign o_status.y_gt        = r_dvd > {{(CELL_W-BYTE_W){1'b0}}, i_cfg.scroll_rows};
    assign o_status.clear_done  = &r_clr;
    assign o_status.two_results = r_n[1];

    assign o_cell_write_valid = (r_n != '0);
    assign o_cell_address     = r_addr[i_out_sel];
    assign o_cell_word        = r_word[i_out_sel];
    assign o_cursor_offset    = r_offs;
    assign o_window_start     = r_ds;
    assign o_last_result      = i_out_sel | ~r_n[1];

endmodule
`default_nettype wire

// ----- hdl/tccw_ctrl.sv -----
// Controller state machine: sequences datapath commands per character
// and runs both handshakes. Depends on tccw_pkg.
`default_nettype none
module tccw_ctrl
    import tccw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_char_valid,
    input  wire logic       i_res_ready,
    input  wire logic       i_follow,
    input  wire t_dp_status i_status,
    output logic      o_char_ready,
    output logic      o_res_valid,
    output logic      o_out_sel,
    output t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_NL_DIV,
        S_NL_MUL,
        S_NL_SET,
        S_MARK_RD,
        S_MARK_PUT,
        S_SC_START,
        S_SC_DIV,
        S_SC_CHK,
        S_SC_SET,
        S_OFFS,
        S_OUT0,
        S_OUT1
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_char_ready = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_OUT0) || (r_state == S_OUT1);
    assign o_out_sel    = (r_state == S_OUT1);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd = CMD_CLEAR;
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_char_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_status.cls == CLS_NL) begin
                    o_cmd   = CMD_DIV_WP;
                    n_state = S_NL_DIV;
                end else begin
                    o_cmd   = CMD_APPLY;
                    n_state = (i_status.cls == CLS_BS) ? S_SC_START : S_MARK_RD;
                end
            end
            S_NL_DIV: begin
                o_cmd = CMD_DIV_STEP;
                if (i_status.div_last) begin
                    n_state = S_NL_MUL;
                end
            end
            S_NL_MUL: begin
                o_cmd   = CMD_NL_MUL;
                n_state = S_NL_SET;
            end
            S_NL_SET: begin
                o_cmd   = CMD_NL_SET;
                n_state = S_MARK_RD;
            end
            S_MARK_RD: begin
                if (i_follow) begin
                    o_cmd   = CMD_MARK_RD;
                    n_state = S_MARK_PUT;
                end else begin
                    n_state = S_SC_START;
                end
            end
            S_MARK_PUT: begin
                o_cmd   = CMD_MARK_PUT;
                n_state = S_SC_START;
            end
            S_SC_START: begin
                o_cmd   = CMD_DIV_OFFS;
                n_state = S_SC_DIV;
            end
            S_SC_DIV: begin
                o_cmd = CMD_DIV_STEP;
                if (i_status.div_last) begin
                    n_state = S_SC_CHK;
                end
            end
            S_SC_CHK: begin
                if (i_status.y_gt) begin
                    o_cmd   = CMD_SC_MUL;
                    n_state = S_SC_SET;
                end else begin
                    o_cmd   = CMD_OFFS;
                    n_state = S_OUT0;
                end
            end
            S_SC_SET: begin
                o_cmd   = CMD_SC_SET;
                n_state = S_OFFS;
            end
            S_OFFS: begin
                o_cmd   = CMD_OFFS;
                n_state = S_OUT0;
            end
            S_OUT0: begin
                if (i_res_ready) begin
                    n_state = i_status.two_results ? S_OUT1 : S_IDLE;
                end
            end
            S_OUT1: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/text_console_char_writer_top.sv -----
// Top level of the text console character writer: registers, controller
// and datapath. Depends on tccw_pkg, tccw_regs, tccw_ctrl, tccw_dp.
//
// channel   direction  handshake                      payload
// char      in         i_char_valid / o_char_ready    i_char_code
// result    out        o_res_valid / i_res_ready      o_cell_*, o_cursor_offset, ...
// config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One character at a time. Every character runs the 15-step serial divider
// by the column count once; CR/LF runs it twice. A scroll of the window
// adds a multiply and a window update; BS and cursor_follow 0 skip the
// cursor mark.
// A stall on i_res_ready holds the result.
// After reset a clearing pass zeroes the cell store; no character is
// accepted until it ends.
`default_nettype none
module text_console_char_writer_top
    import tccw_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_char_valid,
    output logic                    o_char_ready,
    input  wire logic [BYTE_W-1:0]  i_char_code,
    output logic                    o_res_valid,
    input  wire logic               i_res_ready,
    output logic                    o_cell_write_valid,
    output logic      [CELL_W-1:0]  o_cell_address,
    output logic      [WORD_W-1:0]  o_cell_word,
    output logic      [CELL_W-1:0]  o_cursor_offset,
    output logic      [CELL_W-1:0]  o_window_start,
    output logic                    o_last_result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;
    logic       out_sel;

    tccw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tccw_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (i_char_valid),
        .i_res_ready  (i_res_ready),
        .i_follow     (cfg.cursor_follow),
        .i_status     (status),
        .o_char_ready (o_char_ready),
        .o_res_valid  (o_res_valid),
        .o_out_sel    (out_sel),
        .o_cmd        (cmd)
    );

    tccw_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (cfg),
        .i_cmd              (cmd),
        .i_char_code        (i_char_code),
        .i_out_sel          (out_sel),
        .o_status           (status),
        .o_cell_write_valid (o_cell_write_valid),
        .o_cell_address     (o_cell_address),
        .o_cell_word        (o_cell_word),
        .o_cursor_offset    (o_cursor_offset),
        .o_window_start     (o_window_start),
        .o_last_result      (o_last_result)
    );

endmodule
`default_nettype wire
